>>> rtl/assert_macros.svh
// Assertion helpers, included by suction_cup_turn_counter_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/sctc_pkg.sv
// ----------------------------------------------------------------------------
// sctc_pkg
// Types and constants for the suction-cup turn counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sctc_pkg;

    localparam int CFG_W  = 12;   // width of the position thresholds
    localparam int SPD_W  = 10;
    localparam int DRV_W  = 11;
    localparam int TURN_W = 4;
    localparam int QUIET_W = 8;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_ENGAGED  = 2'd1,
        MODE_RELEASED = 2'd2
    } mode_t;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_SAMPLE  = 1'b1;

    localparam logic [IDX_W-1:0] REG_DRIVE_SPEED    = 3'd0;
    localparam logic [IDX_W-1:0] REG_STEP_THRESHOLD = 3'd1;
    localparam logic [IDX_W-1:0] REG_GLITCH_LIMIT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_QUIET_SAMPLES  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TURNS_ENGAGE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_TURNS_RELEASE  = 3'd5;
    localparam logic [IDX_W-1:0] REG_TURNS_RESET    = 3'd6;

    localparam logic [SPD_W-1:0]   RST_DRIVE_SPEED    = 10'd800;
    localparam logic [CFG_W-1:0]   RST_STEP_THRESHOLD = 12'd30;
    localparam logic [CFG_W-1:0]   RST_GLITCH_LIMIT   = 12'd1200;
    localparam logic [QUIET_W-1:0] RST_QUIET_SAMPLES  = 8'd8;
    localparam logic [TURN_W-1:0]  RST_TURNS_ENGAGE   = 4'd6;
    localparam logic [TURN_W-1:0]  RST_TURNS_RELEASE  = 4'd8;
    localparam logic [TURN_W-1:0]  RST_TURNS_RESET    = 4'd2;

    localparam logic [QUIET_W-1:0] QUIET_MAX = 8'hFF;

    typedef struct packed {
        logic signed [DRV_W-1:0] drive;
        mode_t                   cup_mode;
        logic [TURN_W-1:0]       turns_done;
        logic                    move_finished;
        logic                    rejected;
        logic                    busy_res;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/suction_cup_turn_counter_core.sv
// A result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one transaction per cycle while the skid entry is empty; all state updates in one pass.
// A two-entry result buffer (output register plus skid) keeps the input
// open for one transaction while the output is stalled.
// Reset (rst_n, async, active low): idle, not moving, config at defaults.
// ----------------------------------------------------------------------------
// suction_cup_turn_counter_core
// Cup mode sequencer with steep-edge turn counting on position samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module suction_cup_turn_counter_core #(
    parameter int POS_BITS = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // APB-style configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sctc_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [sctc_pkg::DATA_W-1:0]         pwdata,
    output logic      [sctc_pkg::DATA_W-1:0]         prdata,
    output logic                                     pready,
    // input channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                opcode,
    input  wire logic [1:0]                          request,
    input  wire logic [sctc_pkg::CFG_W-1:0]          position,
    input  wire logic                                sample_valid,
    // output channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [sctc_pkg::DRV_W-1:0]        drive,
    output logic [1:0]                               cup_mode,
    output logic [sctc_pkg::TURN_W-1:0]              turns_done,
    output logic                                     move_finished,
    output logic                                     rejected,
    output logic                                     busy_res
);
    import sctc_pkg::*;

    // Positions are taken in their low POS_BITS bits, capped at the port width.
    localparam int PW = (POS_BITS < CFG_W) ? POS_BITS : CFG_W;

    // configuration registers
    logic [SPD_W-1:0]   drive_speed_reg;
    logic [CFG_W-1:0]   step_threshold_reg;
    logic [CFG_W-1:0]   glitch_limit_reg;
    logic [QUIET_W-1:0] quiet_samples_reg;
    logic [TURN_W-1:0]  turns_engage_reg;
    logic [TURN_W-1:0]  turns_release_reg;
    logic [TURN_W-1:0]  turns_reset_reg;

    // controller state
    mode_t              cup_mode_reg,    cup_mode_next;
    logic               moving_reg,      moving_next;
    mode_t              target_mode_reg, target_mode_next;
    logic [TURN_W-1:0]  turn_target_reg, turn_target_next;
    logic [TURN_W-1:0]  turn_count_reg,  turn_count_next;
    logic               backward_reg,    backward_next;
    logic [PW-1:0]      prev_pos_reg,    prev_pos_next;
    logic               have_prev_reg,   have_prev_next;
    logic               steep_reg,       steep_next;
    logic [QUIET_W-1:0] quiet_run_reg,   quiet_run_next;

    // result buffer
    logic               out_valid_reg,   out_valid_next;
    res_t               out_res_reg,     out_res_next;
    logic               skid_valid_reg,  skid_valid_next;
    res_t               skid_res_reg,    skid_res_next;

    logic               cfg_write;
    logic [IDX_W-1:0]   cfg_idx;
    logic               in_fire;
    logic               out_fire;
    res_t               res;
    logic               finished;
    logic               reject;
    logic               legal;
    logic [TURN_W-1:0]  legal_turns;
    logic               legal_back;
    logic [PW-1:0]      pos_w;
    logic [PW-1:0]      grad;
    logic [SPD_W:0]     speed_ext;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite & pready;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid_reg & out_ready;
    assign pos_w     = position[PW-1:0];
    assign grad      = (pos_w >= prev_pos_reg) ? (pos_w - prev_pos_reg)
                                               : (prev_pos_reg - pos_w);
    assign speed_ext = {1'b0, drive_speed_reg};

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_speed_reg    <= RST_DRIVE_SPEED;
            step_threshold_reg <= RST_STEP_THRESHOLD;
            glitch_limit_reg   <= RST_GLITCH_LIMIT;
            quiet_samples_reg  <= RST_QUIET_SAMPLES;
            turns_engage_reg   <= RST_TURNS_ENGAGE;
            turns_release_reg  <= RST_TURNS_RELEASE;
            turns_reset_reg    <= RST_TURNS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_DRIVE_SPEED:    drive_speed_reg    <= pwdata[SPD_W-1:0];
                REG_STEP_THRESHOLD: step_threshold_reg <= pwdata[CFG_W-1:0];
                REG_GLITCH_LIMIT:   glitch_limit_reg   <= pwdata[CFG_W-1:0];
                REG_QUIET_SAMPLES:  quiet_samples_reg  <= pwdata[QUIET_W-1:0];
                REG_TURNS_ENGAGE:   turns_engage_reg   <= pwdata[TURN_W-1:0];
                REG_TURNS_RELEASE:  turns_release_reg  <= pwdata[TURN_W-1:0];
                REG_TURNS_RESET:    turns_reset_reg    <= pwdata[TURN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_DRIVE_SPEED:    prdata = DATA_W'(drive_speed_reg);
            REG_STEP_THRESHOLD: prdata = DATA_W'(step_threshold_reg);
            REG_GLITCH_LIMIT:   prdata = DATA_W'(glitch_limit_reg);
            REG_QUIET_SAMPLES:  prdata = DATA_W'(quiet_samples_reg);
            REG_TURNS_ENGAGE:   prdata = DATA_W'(turns_engage_reg);
            REG_TURNS_RELEASE:  prdata = DATA_W'(turns_release_reg);
            REG_TURNS_RESET:    prdata = DATA_W'(turns_reset_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // legal move decode
    // ------------------------------------------------------------------
    always_comb
    begin
        legal       = 1'b0;
        legal_turns = turns_engage_reg;
        legal_back  = 1'b0;
        case (cup_mode_reg)
            MODE_IDLE:
            begin
                legal       = (request == MODE_ENGAGED);
                legal_turns = turns_engage_reg;
            end
            MODE_ENGAGED:
            begin
                legal       = (request == MODE_RELEASED);
                legal_turns = turns_release_reg;
                legal_back  = 1'b1;
            end
            MODE_RELEASED:
            begin
                legal       = (request == MODE_IDLE);
                legal_turns = turns_reset_reg;
            end
            default:
            begin
                legal = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // next state for one transaction
    // ------------------------------------------------------------------
    always_comb
    begin
        cup_mode_next    = cup_mode_reg;
        moving_next      = moving_reg;
        target_mode_next = target_mode_reg;
        turn_target_next = turn_target_reg;
        turn_count_next  = turn_count_reg;
        backward_next    = backward_reg;
        prev_pos_next    = prev_pos_reg;
        have_prev_next   = have_prev_reg;
        steep_next       = steep_reg;
        quiet_run_next   = quiet_run_reg;
        finished         = 1'b0;
        reject           = 1'b0;

        if (opcode == OP_REQUEST)
        begin
            if (moving_reg || !legal)
            begin
                reject = 1'b1;
            end
            else
            begin
                target_mode_next = mode_t'(request);
                turn_target_next = legal_turns;
                backward_next    = legal_back;
                moving_next      = 1'b1;
                turn_count_next  = '0;
                steep_next       = 1'b0;
                quiet_run_next   = '0;
                have_prev_next   = 1'b0;
                // zero-turn move completes on the request itself
                if (legal_turns == '0)
                begin
                    moving_next   = 1'b0;
                    cup_mode_next = mode_t'(request);
                    finished      = 1'b1;
                end
            end
        end
        else if (moving_reg && sample_valid)
        begin
            if (!have_prev_reg)
            begin
                prev_pos_next  = pos_w;
                have_prev_next = 1'b1;
            end
            else if (CFG_W'(grad) <= glitch_limit_reg)
            begin
                if (CFG_W'(grad) > step_threshold_reg)
                begin
                    steep_next     = 1'b1;
                    quiet_run_next = '0;
                end
                else if (quiet_run_reg != QUIET_MAX)
                begin
                    quiet_run_next = quiet_run_reg + 1'b1;
                end
                if (quiet_run_next >= quiet_samples_reg)
                begin
                    steep_next = 1'b0;
                end
                // falling edge of steep counts a turn
                if (steep_reg && !steep_next)
                begin
                    turn_count_next = turn_count_reg + 1'b1;
                end
                prev_pos_next = pos_w;
                if (turn_count_next >= turn_target_reg)
                begin
                    moving_next   = 1'b0;
                    cup_mode_next = target_mode_reg;
                    finished      = 1'b1;
                end
            end
        end
    end

    // result of the transaction
    always_comb
    begin
        res.drive         = '0;
        if (moving_next)
        begin
            res.drive = backward_next ? -$signed(speed_ext) : $signed(speed_ext);
        end
        res.cup_mode      = cup_mode_next;
        res.turns_done    = turn_count_next;
        res.move_finished = finished;
        res.rejected      = reject;
        res.busy_res      = moving_next;
    end

    // ------------------------------------------------------------------
    // output register plus skid entry
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                out_res_next   = res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cup_mode_reg    <= MODE_IDLE;
            moving_reg      <= 1'b0;
            target_mode_reg <= MODE_IDLE;
            turn_target_reg <= '0;
            turn_count_reg  <= '0;
            backward_reg    <= 1'b0;
            have_prev_reg   <= 1'b0;
            steep_reg       <= 1'b0;
            quiet_run_reg   <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                cup_mode_reg    <= cup_mode_next;
                moving_reg      <= moving_next;
                target_mode_reg <= target_mode_next;
                turn_target_reg <= turn_target_next;
                turn_count_reg  <= turn_count_next;
                backward_reg    <= backward_next;
                have_prev_reg   <= have_prev_next;
                steep_reg       <= steep_next;
                quiet_run_reg   <= quiet_run_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            prev_pos_reg <= prev_pos_next;
        end
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid     = out_valid_reg;
    assign drive         = out_res_reg.drive;
    assign cup_mode      = out_res_reg.cup_mode;
    assign turns_done    = out_res_reg.turns_done;
    assign move_finished = out_res_reg.move_finished;
    assign rejected      = out_res_reg.rejected;
    assign busy_res      = out_res_reg.busy_res;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
        in_fire && out_valid_reg && !out_ready, skid_valid_reg)
    `ASSERT_IMP(a_move_changes_mode, clk, rst_n, moving_reg,
        target_mode_reg != cup_mode_reg)
    `ASSERT_IMP(a_finish_not_busy, clk, rst_n,
        out_valid_reg && out_res_reg.move_finished, !out_res_reg.busy_res)

endmodule

`default_nettype wire
